// ----- rtl/smoothed_exp_vco_dds_defines.svh -----
// assertion macros for the smoothed exponential vco dds
// used by the top level; no other dependencies
`ifndef SMOOTHED_EXP_VCO_DDS_DEFINES_SVH
`define SMOOTHED_EXP_VCO_DDS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smv assertion failed");

// antecedent implies consequent in the next cycle
`define SMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smv assertion failed");

`endif

// ----- rtl/smv_pkg.sv -----
// shared constants, types and sine table for the smoothed exponential vco dds
// no dependencies
`timescale 1ns / 1ps

package smv_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
    localparam int ROM_IDX_W = SINE_TABLE_BITS - 1;

    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 24;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [30:0] Q30_ONE    = 31'd1073741824;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [23:0] PITCH_DIV  = 24'd10485760;

    localparam logic [30:0] RST_BASE_STEP = 31'd3511479;
    localparam logic [15:0] RST_SLOPE     = 16'd2048;
    localparam logic [14:0] RST_AMPLITUDE = 15'd3277;
    localparam logic [19:0] RST_TAU       = 20'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_STEP = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_AMPLITUDE = 2'd2,
        CFG_TAU       = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOADV, OP_XDIV, OP_YMUL, OP_AZERO, OP_EXP_INIT, OP_EMUL,
        OP_EDIV, OP_ESTEP, OP_AFILT, OP_FMUL, OP_FADD, OP_PMUL, OP_PDIV,
        OP_PEXP, OP_MMUL, OP_STEP, OP_TROM, OP_TOUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_LOADV, S_XDIV, S_XWAIT, S_YMUL, S_YCHK, S_EINIT, S_EMUL,
        S_EDIV, S_EWAIT, S_AFILT, S_FMUL, S_FADD, S_PMUL, S_PDIV, S_PWAIT,
        S_MMUL, S_STEP, S_TROM, S_TOUT
    } t_state;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic x_big;
        logic n_big;
        logic k_one;
        logic out_full;
    } t_stat;

    typedef logic [SAMPLE_BITS-1:0] t_sine_tab [QUARTER+1];

    // quarter-wave magnitude, entries 0 to a full quarter inclusive
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] one;
        logic [63:0] vmax;
        one  = 64'd1 << 30;
        vmax = 64'd1 << (SAMPLE_BITS - 1);
        for (int r = 0; r <= QUARTER; r++) begin
            th  = (64'(r) * 64'(HALFPI_Q30)) >> (SINE_TABLE_BITS - 2);
            th2 = (th * th) >> 30;
            t   = one;
            for (int j = 7; j >= 1; j--) begin
                t = one - ((th2 * t) >> 30) / 64'((2 * j) * (2 * j + 1));
            end
            s = (th * t) >> 30;
            if (s > one) s = one;
            v = (s + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
            if (v > vmax) v = vmax;
            tab[r] = v[SAMPLE_BITS-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/smv_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on smv_pkg
`timescale 1ns / 1ps

module smv_div
    import smv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dsr;
    logic [DIV_D_W:0]     rem_sh;
    logic                 fits;

    assign rem_sh = {r_rem, r_quo[DIV_N_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_D_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/smv_dp.sv -----
// datapath: configuration, oscillator state, filter, exponent and sine output
// depends on smv_pkg and smv_div
`timescale 1ns / 1ps

module smv_dp
    import smv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [15:0]           i_voltage_mv,
    input  logic [19:0]           i_elapsed_us,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic signed [15:0]    o_sample
);

    localparam logic [63:0] HALF64 = 64'd1 << (PHASE_BITS - 1);
    // pitch divisor is 10 * 2^20: shift by 20, then divide by 10 by reciprocal
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    logic [30:0]           r_base_step;
    logic signed [15:0]    r_slope;
    logic [14:0]           r_amp;
    logic [19:0]           r_tau;
    logic [15:0]           r_vin;
    logic [19:0]           r_dt;
    logic signed [31:0]    r_v;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [15:0]           r_f;
    logic [5:0]            r_yn;
    logic [29:0]           r_u;
    logic [30:0]           r_e;
    logic [30:0]           r_t;
    logic [3:0]            r_k;
    logic [30:0]           r_a;
    logic [31:0]           r_p;
    logic                  r_dneg;
    logic [46:0]           r_pmag;
    logic                  r_up;
    logic [23:0]           r_eq;
    logic signed [9:0]     r_sh;
    logic [61:0]           r_m;
    logic [SAMPLE_BITS-1:0] r_smag;
    logic                  r_sneg;
    logic                  r_out_valid;
    logic signed [15:0]    r_sample;

    logic                  div_start;
    logic [DIV_N_W-1:0]    div_n;
    logic [DIV_D_W-1:0]    div_d;
    logic                  div_done;
    logic [DIV_N_W-1:0]    quo;

    logic [51:0]           y_full;
    logic [45:0]           u_full;
    logic [60:0]           t_full;
    logic [30:0]           w;
    logic [32:0]           d;
    logic [32:0]           dmag;
    logic [63:0]           p_full;
    logic signed [47:0]    prod;
    logic [47:0]           prod_mag;
    logic [58:0]           eq_full;
    logic [23:0]           eq;
    logic [24:0]           eq_up;
    logic [8:0]            n_up;
    logic [24:0]           g_up;
    logic [63:0]           sat_v;
    logic [9:0]            sh_amt;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic [ROM_IDX_W-1:0]  rom_r;
    logic [14+SAMPLE_BITS:0] amp_prod;
    logic [15+SAMPLE_BITS:0] amp_rnd;
    logic [16:0]           rr;
    logic [14:0]           rr_sat;

    smv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = 24'd1;
        case (i_cmd.op)
            OP_XDIV: begin
                div_start = 1'b1;
                div_n     = DIV_N_W'({r_dt, 16'd0});
                div_d     = (r_tau == '0) ? 24'd1 : DIV_D_W'(r_tau);
            end
            OP_EDIV: begin
                div_start = 1'b1;
                div_n     = DIV_N_W'(r_t);
                div_d     = DIV_D_W'(r_k);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        y_full   = 52'(quo[20:0]) * 52'(LOG2E_Q30);
        u_full   = 46'(r_f) * 46'(LN2_Q30);
        t_full   = 61'(r_u) * 61'(r_e);
        w        = Q30_ONE - r_a;
        d        = $signed({r_vin[15], r_vin, 16'd0}) - $signed({r_v[31], r_v});
        dmag     = d[32] ? 33'(-d) : d;
        p_full   = 64'(dmag) * 64'(w) + (64'd1 << 29);
        prod     = 48'(r_v) * 48'(r_slope);
        prod_mag = prod[47] ? 48'(-prod) : prod;
        eq_full  = 59'(r_pmag[46:20]) * 59'(DIV10_RECIP);
        eq       = r_eq;
        eq_up    = {1'b0, eq} + 25'h0FFFF;
        n_up     = eq_up[24:16];
        g_up     = {n_up, 16'd0} - {1'b0, eq};
    end

    // m * 2^sh with saturation at half scale
    always_comb begin
        sh_amt = 10'(-r_sh);
        sat_v  = '0;
        if (r_sh < 0) begin
            sat_v = (sh_amt >= 10'd62) ? 64'd0 : (64'(r_m) >> sh_amt[5:0]);
        end else if (r_m == '0) begin
            sat_v = '0;
        end else if (r_sh >= 10'sd48 || r_sh >= 10'(PHASE_BITS)) begin
            sat_v = HALF64;
        end else if (64'(r_m) > (HALF64 >> r_sh[5:0])) begin
            sat_v = HALF64;
        end else begin
            sat_v = 64'(r_m) << r_sh[5:0];
        end
        if (sat_v > HALF64) sat_v = HALF64;
    end

    // sine lookup and amplitude scaling
    always_comb begin
        rom_idx  = r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        rom_r    = rom_idx[SINE_TABLE_BITS-2] ?
                   ROM_IDX_W'(QUARTER - int'(rom_idx[SINE_TABLE_BITS-3:0])) :
                   ROM_IDX_W'(rom_idx[SINE_TABLE_BITS-3:0]);
        amp_prod = (15+SAMPLE_BITS)'(r_amp) * (15+SAMPLE_BITS)'(r_smag);
        amp_rnd  = (16+SAMPLE_BITS)'(amp_prod) + ((16+SAMPLE_BITS)'(1) << (SAMPLE_BITS - 2));
        rr       = 17'(amp_rnd >> (SAMPLE_BITS - 1));
        rr_sat   = (rr > 17'd32767) ? 15'h7FFF : rr[14:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step <= RST_BASE_STEP;
            r_slope     <= RST_SLOPE;
            r_amp       <= RST_AMPLITUDE;
            r_tau       <= RST_TAU;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_STEP: r_base_step <= i_cfg_data[30:0];
                CFG_SLOPE:     r_slope     <= i_cfg_data[15:0];
                CFG_AMPLITUDE: r_amp       <= i_cfg_data[14:0];
                CFG_TAU:       r_tau       <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    // oscillator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_phase     <= '0;
            r_step      <= PHASE_BITS'(RST_BASE_STEP);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_LOADV: r_v <= {r_vin, 16'd0};
                OP_FADD:  r_v <= r_dneg ? (r_v - r_p) : (r_v + r_p);
                OP_STEP:  r_step <= sat_v[PHASE_BITS-1:0];
                OP_TOUT: begin
                    r_out_valid <= 1'b1;
                    r_phase     <= r_phase + r_step;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_vin <= i_voltage_mv;
            r_dt  <= i_elapsed_us;
        end
        case (i_cmd.op)
            OP_YMUL: begin
                r_f  <= y_full[45:30];
                r_yn <= y_full[51:46];
            end
            OP_AZERO:    r_a <= '0;
            OP_EXP_INIT: begin
                r_u <= u_full[45:16];
                r_e <= Q30_ONE;
                r_k <= 4'd10;
            end
            OP_EMUL:  r_t <= t_full[60:30];
            OP_ESTEP: begin
                r_e <= Q30_ONE - quo[30:0];
                r_k <= r_k - 1'b1;
            end
            OP_AFILT: r_a <= r_e >> r_yn;
            OP_FMUL: begin
                r_p    <= p_full[61:30];
                r_dneg <= d[32];
            end
            OP_PMUL: begin
                r_pmag <= prod_mag[46:0];
                r_up   <= prod[47];
            end
            OP_PDIV: r_eq <= eq_full[58:35];
            OP_PEXP: begin
                if (r_up) begin
                    r_f  <= g_up[15:0];
                    r_sh <= $signed({1'b0, n_up}) - 10'sd30;
                end else begin
                    r_f  <= eq[15:0];
                    r_sh <= -($signed({2'b0, eq[23:16]}) + 10'sd30);
                end
            end
            OP_MMUL: r_m <= 62'(r_base_step) * 62'(r_e);
            OP_TROM: begin
                r_smag <= SINE_TAB[rom_r];
                r_sneg <= rom_idx[SINE_TABLE_BITS-1];
            end
            OP_TOUT: r_sample <= r_sneg ? -$signed({1'b0, rr_sat}) : $signed({1'b0, rr_sat});
            default: begin
            end
        endcase
    end

    assign o_stat.div_done = div_done;
    assign o_stat.x_big    = |quo[DIV_N_W-1:21];
    assign o_stat.n_big    = r_yn >= 6'd31;
    assign o_stat.k_one    = r_k == 4'd1;
    assign o_stat.out_full = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// ----- rtl/smv_ctrl.sv -----
// controller state machine sequencing voltage and tick transactions
// depends on smv_pkg
`timescale 1ns / 1ps

module smv_ctrl
    import smv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_func,
    input  logic  i_dt_zero,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_pitch;
    logic   n_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pitch <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pitch <= n_pitch;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pitch      = r_pitch;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NONE;
        o_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_func)         n_state = S_TROM;
                    else if (i_dt_zero) n_state = S_LOADV;
                    else                n_state = S_XDIV;
                end
            end
            S_LOADV: begin
                o_cmd.op = OP_LOADV;
                n_state  = S_PMUL;
            end
            S_XDIV: begin
                o_cmd.op = OP_XDIV;
                n_state  = S_XWAIT;
            end
            S_XWAIT: if (i_stat.div_done) n_state = S_YMUL;
            S_YMUL: begin
                if (i_stat.x_big) begin
                    o_cmd.op = OP_AZERO;
                    n_state  = S_FMUL;
                end else begin
                    o_cmd.op = OP_YMUL;
                    n_state  = S_YCHK;
                end
            end
            S_YCHK: begin
                n_pitch = 1'b0;
                if (i_stat.n_big) begin
                    o_cmd.op = OP_AZERO;
                    n_state  = S_FMUL;
                end else begin
                    n_state = S_EINIT;
                end
            end
            S_EINIT: begin
                o_cmd.op = OP_EXP_INIT;
                n_state  = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.op = OP_EMUL;
                n_state  = S_EDIV;
            end
            S_EDIV: begin
                o_cmd.op = OP_EDIV;
                n_state  = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_ESTEP;
                    if (!i_stat.k_one) n_state = S_EMUL;
                    else if (r_pitch)  n_state = S_MMUL;
                    else               n_state = S_AFILT;
                end
            end
            S_AFILT: begin
                o_cmd.op = OP_AFILT;
                n_state  = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.op = OP_FMUL;
                n_state  = S_FADD;
            end
            S_FADD: begin
                o_cmd.op = OP_FADD;
                n_state  = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.op = OP_PMUL;
                n_state  = S_PDIV;
            end
            S_PDIV: begin
                o_cmd.op = OP_PDIV;
                n_state  = S_PWAIT;
            end
            // exponent split, in the cycle after the reciprocal divide
            S_PWAIT: begin
                o_cmd.op = OP_PEXP;
                n_pitch  = 1'b1;
                n_state  = S_EINIT;
            end
            S_MMUL: begin
                o_cmd.op = OP_MMUL;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_IDLE;
            end
            S_TROM: begin
                o_cmd.op = OP_TROM;
                n_state  = S_TOUT;
            end
            S_TOUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.op = OP_TOUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/smoothed_exp_vco_dds.sv -----
// smoothed exponential vco dds top level: controller, datapath and checks
// tick transaction: sine table read, then the result register is loaded once it is empty
// voltage transaction: direct or smoothed, paced by the bit-serial divider, used 10 times
// direct and 11 or 21 times smoothed; no result
// synchronous active-low reset; config, smoothed voltage, phase and step reset
`timescale 1ns / 1ps
`include "smoothed_exp_vco_dds_defines.svh"

module smoothed_exp_vco_dds
    import smv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic signed [15:0]    i_voltage_mv,
    input  logic [19:0]           i_elapsed_us,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_sample,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  ready;
    logic  in_acc;

    // a transaction is taken only while the controller sits idle
    assign o_in_stall = !ready;
    assign in_acc     = i_in_valid && ready;

    smv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_dt_zero  (i_elapsed_us == '0),
        .i_stat     (stat),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    // the result register lets a new transaction in while a sample waits
    smv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_voltage_mv (i_voltage_mv),
        .i_elapsed_us (i_elapsed_us),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample     (o_sample)
    );

    // a tick into an empty result register shows a sample after the table read and the output load
    `SMV_ASSERT_IMP(a_tick_result, i_clk, i_rst_n, in_acc && i_func && !o_out_valid, ##3 o_out_valid)
    // a voltage transaction keeps the input stalled while it works
    `SMV_ASSERT_NEXT(a_volt_busy, i_clk, i_rst_n, in_acc && !i_func, o_in_stall)
    // the sequencer never starts a divide while the controller is idle
    `SMV_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, ready, cmd.op == OP_NONE)

endmodule
